@@ rtl/cls_pkg.sv @@
// shared types and constants for the rgb background/foreground classifier
// no dependencies; used by cls_front, cls_back and the top level
package cls_pkg;

  localparam int unsigned PixW   = 8;   // one color channel
  localparam int unsigned DotW   = 18;  // three-term sum of 8x8 products
  localparam int unsigned ProdW  = 36;  // product of two dot sums
  localparam int unsigned LevelW = 8;
  localparam int unsigned ColorW = 9;
  localparam int unsigned SqW    = 18;  // color threshold squared
  localparam int unsigned DevW   = 25;  // 100 times brightness deviation
  localparam int unsigned TbW    = 26;  // level threshold times b
  localparam int unsigned CfgAddrW = 2;

  localparam logic [LevelW-1:0] LevelReset = 8'd24;
  localparam logic [ColorW-1:0] ColorReset = 9'd24;
  localparam logic [LevelW-1:0] FlagLevel  = 8'd255;
  localparam logic [DevW-1:0]   PctScale   = 25'd100;

  // configuration register indexes
  typedef enum logic [CfgAddrW-1:0] {
    CFG_DIFF_METHOD     = 2'd0,
    CFG_LEVEL_THRESHOLD = 2'd1,
    CFG_COLOR_THRESHOLD = 2'd2
  } cfg_idx_e;

  // dot products and max channel difference of one pixel
  typedef struct packed {
    logic [DotW-1:0]   a;     // cur . bg
    logic [DotW-1:0]   b;     // bg . bg
    logic [DotW-1:0]   s;     // cur . cur
    logic [PixW-1:0]   maxd;  // largest absolute channel difference
  } front_t;

  // live configuration seen by the pipeline
  typedef struct packed {
    logic              diff_method;
    logic [LevelW-1:0] level_threshold;
    logic [SqW-1:0]    color_sq;
  } cfg_t;

endpackage

@@ rtl/cls_front.sv @@
// front half of the pipeline: channel products and differences, then dot sums
// depends on cls_pkg
module cls_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [7:0]            cur_red_i,
  input  logic [7:0]            cur_green_i,
  input  logic [7:0]            cur_blue_i,
  input  logic [7:0]            bg_red_i,
  input  logic [7:0]            bg_green_i,
  input  logic [7:0]            bg_blue_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output cls_pkg::front_t       out_data_o
);
  import cls_pkg::*;

  logic [2:0][PixW-1:0]   cur, bg;
  logic [2:0][2*PixW-1:0] pcb_d, pbb_d, pcc_d;
  logic [2:0][2*PixW-1:0] pcb_q, pbb_q, pcc_q;
  logic [2:0][PixW-1:0]   absd_d, absd_q;
  logic                   v1_q, v2_q;
  logic                   rdy1, rdy2;
  front_t                 dot_d, dot_q;
  logic [PixW-1:0]        max01;

  assign cur = {cur_blue_i, cur_green_i, cur_red_i};
  assign bg  = {bg_blue_i, bg_green_i, bg_red_i};

  // stage ready chain: a stage moves when it is empty or its successor moves
  assign rdy2       = ~v2_q | out_ready_i;
  assign rdy1       = ~v1_q | rdy2;
  assign in_ready_o = rdy1;

  // stage 1 logic: per-channel products and absolute differences
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pcb_d[i]  = {{PixW{1'b0}}, cur[i]} * {{PixW{1'b0}}, bg[i]};
      pbb_d[i]  = {{PixW{1'b0}}, bg[i]} * {{PixW{1'b0}}, bg[i]};
      pcc_d[i]  = {{PixW{1'b0}}, cur[i]} * {{PixW{1'b0}}, cur[i]};
      absd_d[i] = (cur[i] > bg[i]) ? (cur[i] - bg[i]) : (bg[i] - cur[i]);
    end
  end

  // stage 2 logic: three-term sums and max difference
  always_comb begin
    dot_d.a = DotW'(pcb_q[0]) + DotW'(pcb_q[1]) + DotW'(pcb_q[2]);
    dot_d.b = DotW'(pbb_q[0]) + DotW'(pbb_q[1]) + DotW'(pbb_q[2]);
    dot_d.s = DotW'(pcc_q[0]) + DotW'(pcc_q[1]) + DotW'(pcc_q[2]);
    max01   = (absd_q[1] > absd_q[0]) ? absd_q[1] : absd_q[0];
    dot_d.maxd = (absd_q[2] > max01) ? absd_q[2] : max01;
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      pcb_q  <= pcb_d;
      pbb_q  <= pbb_d;
      pcc_q  <= pcc_d;
      absd_q <= absd_d;
    end
    if (rdy2 && v1_q) begin
      dot_q <= dot_d;
    end
  end

  assign out_valid_o = v2_q;
  assign out_data_o  = dot_q;

endmodule

@@ rtl/cls_back.sv @@
// back half of the pipeline: cross products, then threshold compares and result
// depends on cls_pkg
module cls_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cls_pkg::cfg_t         cfg_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  cls_pkg::front_t       in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  is_foreground_o,
  output logic [7:0]            diff_level_o
);
  import cls_pkg::*;

  logic              v3_q, v4_q;
  logic              rdy3, rdy4;
  logic [DotW-1:0]   dev;
  logic [ProdW-1:0]  sb_q, aa_q, c2b_q;
  logic [DevW-1:0]   dev100_q;
  logic [TbW-1:0]    tb_q;
  logic              bz_q;
  logic [PixW-1:0]   maxd_q;
  logic [ProdW:0]    rhs;
  logic              bright, color, fg_d;
  logic [LevelW-1:0] level_d;
  logic              fg_q;
  logic [LevelW-1:0] level_q;

  assign rdy4       = ~v4_q | out_ready_i;
  assign rdy3       = ~v3_q | rdy4;
  assign in_ready_o = rdy3;

  // stage 3 logic: brightness deviation
  assign dev = (in_data_i.a > in_data_i.b) ? (in_data_i.a - in_data_i.b)
                                           : (in_data_i.b - in_data_i.a);

  // stage 4 logic: distortion compares or max-difference compare
  always_comb begin
    rhs    = {1'b0, aa_q} + {1'b0, c2b_q};
    bright = {1'b0, dev100_q} > tb_q;
    color  = {1'b0, sb_q} > rhs;
    if (cfg_i.diff_method) begin
      fg_d    = maxd_q > cfg_i.level_threshold;
      level_d = maxd_q;
    end else begin
      fg_d    = ~bz_q & (bright | color);
      level_d = fg_d ? FlagLevel : '0;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy3) v3_q <= in_valid_i;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // payload registers: one multiply per path in stage 3
  always_ff @(posedge clk_i) begin
    if (rdy3 && in_valid_i) begin
      sb_q     <= ProdW'(in_data_i.s) * ProdW'(in_data_i.b);
      aa_q     <= ProdW'(in_data_i.a) * ProdW'(in_data_i.a);
      c2b_q    <= ProdW'(cfg_i.color_sq) * ProdW'(in_data_i.b);
      dev100_q <= DevW'(dev) * PctScale;
      tb_q     <= TbW'(cfg_i.level_threshold) * TbW'(in_data_i.b);
      bz_q     <= (in_data_i.b == '0);
      maxd_q   <= in_data_i.maxd;
    end
    if (rdy4 && v3_q) begin
      fg_q    <= fg_d;
      level_q <= level_d;
    end
  end

  assign out_valid_o     = v4_q;
  assign is_foreground_o = fg_q;
  assign diff_level_o    = level_q;

endmodule

@@ rtl/rgb_background_foreground_classifier_top.sv @@
// top level of the rgb background/foreground classifier: config registers
// and the four-stage pipeline; depends on cls_pkg, cls_front and cls_back
//
// throughput: one pixel per cycle; the pipeline stalls only when out_ready_i is low
// reset: diff_method 0, level_threshold 24, color_threshold 24, pipeline empty
// a color threshold write lands in color_thr_q, then its square is registered in color_sq_q
module rgb_background_foreground_classifier_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [cls_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [8:0]                  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  cur_red_i,
  input  logic [7:0]                  cur_green_i,
  input  logic [7:0]                  cur_blue_i,
  input  logic [7:0]                  bg_red_i,
  input  logic [7:0]                  bg_green_i,
  input  logic [7:0]                  bg_blue_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        is_foreground_o,
  output logic [7:0]                  diff_level_o
);
  import cls_pkg::*;

  logic              method_q;
  logic [LevelW-1:0] level_thr_q;
  logic [ColorW-1:0] color_thr_q;
  logic [SqW-1:0]    color_sq_q;
  cfg_t              cfg;
  front_t            mid_data;
  logic              mid_valid, mid_ready;

  // configuration registers; unknown indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      method_q    <= 1'b0;
      level_thr_q <= LevelReset;
      color_thr_q <= ColorReset;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_DIFF_METHOD:     method_q    <= cfg_wdata_i[0];
        CFG_LEVEL_THRESHOLD: level_thr_q <= cfg_wdata_i[LevelW-1:0];
        CFG_COLOR_THRESHOLD: color_thr_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // squared color threshold, registered ahead of its use in stage 3
  always_ff @(posedge clk_i) begin
    color_sq_q <= SqW'(color_thr_q) * SqW'(color_thr_q);
  end

  assign cfg.diff_method     = method_q;
  assign cfg.level_threshold = level_thr_q;
  assign cfg.color_sq        = color_sq_q;

  cls_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cur_red_i   (cur_red_i),
    .cur_green_i (cur_green_i),
    .cur_blue_i  (cur_blue_i),
    .bg_red_i    (bg_red_i),
    .bg_green_i  (bg_green_i),
    .bg_blue_i   (bg_blue_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (mid_valid),
    .out_ready_i (mid_ready),
    .out_data_o  (mid_data)
  );

  cls_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .in_valid_i      (mid_valid),
    .in_ready_o      (mid_ready),
    .in_data_i       (mid_data),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .is_foreground_o (is_foreground_o),
    .diff_level_o    (diff_level_o)
  );

`ifndef SYNTH
  // input side only backs up when a result is held at the output
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled while output not blocked");

  // max-difference mode: flag agrees with the level and threshold
  a_mode1_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && method_q) |-> (is_foreground_o == (diff_level_o > level_thr_q)))
    else $error("mode 1 flag disagrees with level");

  // distortion mode: level mirrors the flag
  a_mode0_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !method_q) |->
      (diff_level_o == (is_foreground_o ? FlagLevel : 8'd0)))
    else $error("mode 0 level does not mirror flag");
`endif

endmodule
